/* hw/rtl/asps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asps_pkg
// Shared types and codes of the active slave poll scheduler: transaction
// payloads, the classified operation passed from front end to back end, and
// event kind codes.
// ----------------------------------------------------------------------------
package asps_pkg;

   // Event kind codes
   localparam logic [2:0] KIND_RESPONSE = 3'd0;
   localparam logic [2:0] KIND_TIMEOUT  = 3'd1;
   localparam logic [2:0] KIND_MARK     = 3'd2;
   localparam logic [2:0] KIND_NEXT     = 3'd3;
   localparam logic [2:0] KIND_CLEAR    = 3'd4;

   // Miss counter saturation value
   localparam logic [7:0] MISS_SATURATE = 8'd255;

   // Operation queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // Configuration register selects (bit 2 of the register byte address)
   localparam logic ADDR_MAX_MISSES  = 1'b0;
   localparam logic ADDR_ACTIVE_ONLY = 1'b1;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] slave_address;
      logic       mark_value;
   } req_type;

   typedef struct packed {
      logic [6:0] poll_address;
      logic       slave_is_active;
      logic       any_active;
   } rsp_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] addr;
      logic       mark;
      logic       addr_ok;
   } op_type;

endpackage
`default_nettype wire

/* hw/rtl/active_slave_poll_scheduler.sv */
`default_nettype none
// Path: the front end registers each request, the queue buffers it, and the
// back end executes it and registers the response; a timeout adds a miss
// counter read-modify-write. The back end takes a new operation only when idle;
// a next-poll in active-only mode scans one flag a cycle, up to TOP_ADDRESS probes.
// Reset: synchronous; flags, counter valid bits and the active count clear at
// once, last polled address returns to 1, no clearing pass.
// ----------------------------------------------------------------------------
// active_slave_poll_scheduler
// Round-robin slave poll scheduler with per-slave miss counting; APB-style
// register port for the miss threshold and active-only mode.
// ----------------------------------------------------------------------------
module active_slave_poll_scheduler #(
   parameter int MAX_ADDRESS = 126,
   parameter int TABLE_DEPTH = 128
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  asps_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output asps_pkg::rsp_type rsp_payload,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire  [2:0]        paddr,
   input  wire  [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int TOP_ADDRESS = (MAX_ADDRESS < TABLE_DEPTH - 1) ? MAX_ADDRESS
                                                                : TABLE_DEPTH - 1;

   logic [7:0]       max_misses_ff, max_misses_in;
   logic             active_only_ff, active_only_in;
   logic             push_valid, push_ready, pop_valid, pop_ready;
   asps_pkg::op_type push_op, pop_op;

   // Register port: write on the access phase, read back as stored
   assign pready = 1'b1;

   always_comb begin
      max_misses_in  = max_misses_ff;
      active_only_in = active_only_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[2])
            asps_pkg::ADDR_MAX_MISSES:  max_misses_in  = pwdata[7:0];
            asps_pkg::ADDR_ACTIVE_ONLY: active_only_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         asps_pkg::ADDR_MAX_MISSES:  prdata = {24'd0, max_misses_ff};
         asps_pkg::ADDR_ACTIVE_ONLY: prdata = {31'd0, active_only_ff};
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_misses_ff  <= 8'd3;
         active_only_ff <= 1'b1;
      end else begin
         max_misses_ff  <= max_misses_in;
         active_only_ff <= active_only_in;
      end
   end

   asps_front #(
      .TOP_ADDRESS(TOP_ADDRESS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   asps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_op   (push_op),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_op    (pop_op)
   );

   asps_back #(
      .TOP_ADDRESS(TOP_ADDRESS),
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .max_misses (max_misses_ff),
      .active_only(active_only_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
`default_nettype wire

/* hw/rtl/asps_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asps_front
// Input stage: accepts request transactions, checks the slave address range
// and holds the classified operation until the queue takes it.
// ----------------------------------------------------------------------------
module asps_front #(
   parameter int TOP_ADDRESS = 126
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  asps_pkg::req_type req_payload,
   output logic              push_valid,
   input  wire               push_ready,
   output asps_pkg::op_type  push_op
);

   logic             fv_ff, fv_in;
   asps_pkg::op_type fop_ff, fop_in;
   asps_pkg::op_type cls;

   // Classify the incoming event
   always_comb begin
      cls.kind    = req_payload.kind;
      cls.addr    = req_payload.slave_address;
      cls.mark    = req_payload.mark_value;
      cls.addr_ok = (req_payload.slave_address != 8'd0) &&
                    (req_payload.slave_address <= 8'(TOP_ADDRESS));
   end

   // Hold one operation; take a new one whenever the slot empties
   assign req_ready  = !fv_ff || push_ready;
   assign push_valid = fv_ff;
   assign push_op    = fop_ff;

   always_comb begin
      fv_in  = fv_ff;
      fop_in = fop_ff;
      if (req_valid && req_ready) begin
         fv_in  = 1'b1;
         fop_in = cls;
      end else if (push_ready) begin
         fv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
      fop_ff <= fop_in;
   end

endmodule
`default_nettype wire

/* hw/rtl/asps_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asps_queue
// Short FIFO of classified operations so that the front end and the back end
// stall independently.
// ----------------------------------------------------------------------------
module asps_queue (
   input  wire              clock,
   input  wire              reset,
   input  wire              push_valid,
   output logic             push_ready,
   input  asps_pkg::op_type push_op,
   output logic             pop_valid,
   input  wire              pop_ready,
   output asps_pkg::op_type pop_op
);

   localparam int AW = asps_pkg::QUEUE_AW;

   asps_pkg::op_type entry_ff [asps_pkg::QUEUE_DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in;
   logic [AW-1:0]    rptr_ff, rptr_in;
   logic [AW:0]      fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != (AW+1)'(asps_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_op     = entry_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill count
   always_comb begin
      wptr_in = do_push ? wptr_ff + AW'(1) : wptr_ff;
      rptr_in = do_pop  ? rptr_ff + AW'(1) : rptr_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         entry_ff[wptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/asps_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// asps_back
// Execution stage: keeps the slave table (active flags, miss counters, last
// polled address), carries out each operation and registers the response.
// ----------------------------------------------------------------------------
module asps_back #(
   parameter int TOP_ADDRESS = 126,
   parameter int TABLE_DEPTH = 128
) (
   input  wire               clock,
   input  wire               reset,
   input  wire  [7:0]        max_misses,
   input  wire               active_only,
   input  wire               pop_valid,
   output logic              pop_ready,
   input  asps_pkg::op_type  pop_op,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output asps_pkg::rsp_type rsp_payload
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TOP_ADDRESS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MISS,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   asps_pkg::op_type     op_ff, op_in;
   logic [TABLE_DEPTH-1:0] flags_ff, flags_in;
   logic [TABLE_DEPTH-1:0] cvalid_ff, cvalid_in;
   logic [CW-1:0]        acount_ff, acount_in;
   logic [AW-1:0]        last_ff, last_in;
   logic [AW-1:0]        probe_ff, probe_in;
   logic [AW-1:0]        poll_ff, poll_in;
   logic [7:0]           steps_ff, steps_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   asps_pkg::rsp_type    rsp_ff, rsp_in;

   // Miss counter memory
   logic [7:0]           miss_mem [TABLE_DEPTH];
   logic [7:0]           rd_data_ff;
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [7:0]           wr_data;

   logic [AW-1:0]        hidx, oidx, first;
   logic [7:0]           cur_miss, new_miss;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] a);
      logic [AW-1:0] r;
      if (a == '0 || a >= AW'(TOP_ADDRESS)) begin
         r = AW'(1);
      end else begin
         r = a + AW'(1);
      end
      return r;
   endfunction

   assign hidx      = pop_op.addr[AW-1:0];
   assign oidx      = op_ff.addr[AW-1:0];
   assign first     = advance(last_ff);
   assign cur_miss  = cvalid_ff[oidx] ? rd_data_ff : 8'd0;
   assign new_miss  = (cur_miss == asps_pkg::MISS_SATURATE) ? cur_miss : cur_miss + 8'd1;
   assign pop_ready = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Sequence one operation at a time
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      flags_in     = flags_ff;
      cvalid_in    = cvalid_ff;
      acount_in    = acount_ff;
      last_in      = last_ff;
      probe_in     = probe_ff;
      poll_in      = poll_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = hidx;
      wr_en        = 1'b0;
      wr_addr      = oidx;
      wr_data      = new_miss;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               op_in    = pop_op;
               poll_in  = '0;
               state_in = ST_DONE;
               priority if (pop_op.kind == asps_pkg::KIND_RESPONSE && pop_op.addr_ok) begin
                  // Mark active, miss count back to zero
                  if (!flags_ff[hidx]) begin
                     acount_in = acount_ff + CW'(1);
                  end
                  flags_in[hidx]  = 1'b1;
                  cvalid_in[hidx] = 1'b0;
               end else if (pop_op.kind == asps_pkg::KIND_TIMEOUT && pop_op.addr_ok) begin
                  // Fetch the miss count
                  rd_en    = 1'b1;
                  state_in = ST_MISS;
               end else if (pop_op.kind == asps_pkg::KIND_MARK && pop_op.addr_ok) begin
                  if (pop_op.mark && !flags_ff[hidx]) begin
                     acount_in = acount_ff + CW'(1);
                  end else if (!pop_op.mark && flags_ff[hidx]) begin
                     acount_in = acount_ff - CW'(1);
                  end
                  flags_in[hidx]  = pop_op.mark;
                  cvalid_in[hidx] = 1'b0;
               end else if (pop_op.kind == asps_pkg::KIND_NEXT) begin
                  poll_in = first;
                  if (!active_only || acount_ff == '0) begin
                     last_in = first;
                  end else begin
                     probe_in = first;
                     steps_in = '0;
                     state_in = ST_SCAN;
                  end
               end else if (pop_op.kind == asps_pkg::KIND_CLEAR) begin
                  flags_in  = '0;
                  cvalid_in = '0;
                  acount_in = '0;
                  last_in   = AW'(1);
               end else begin
                  // Out of range address or unused kind: no change
               end
            end
         end
         ST_MISS: begin
            // Bump the count and drop the flag at the threshold
            wr_en           = 1'b1;
            cvalid_in[oidx] = 1'b1;
            if (new_miss >= max_misses) begin
               if (flags_ff[oidx]) begin
                  acount_in = acount_ff - CW'(1);
               end
               flags_in[oidx] = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            // Probe one address a cycle
            if (flags_ff[probe_ff]) begin
               poll_in  = probe_ff;
               last_in  = probe_ff;
               state_in = ST_DONE;
            end else if (steps_ff == 8'(TOP_ADDRESS - 1)) begin
               last_in  = poll_ff;
               state_in = ST_DONE;
            end else begin
               probe_in = advance(probe_ff);
               steps_in = steps_ff + 8'd1;
            end
         end
         ST_DONE: begin
            // Load the response once the output slot is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_in.poll_address    = 7'(poll_ff);
               rsp_in.slave_is_active = op_ff.addr_ok && flags_ff[oidx];
               rsp_in.any_active      = (acount_ff != '0);
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flags_ff     <= '0;
         cvalid_ff    <= '0;
         acount_ff    <= '0;
         last_ff      <= AW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         cvalid_ff    <= cvalid_in;
         acount_ff    <= acount_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff    <= op_in;
      probe_ff <= probe_in;
      poll_ff  <= poll_in;
      steps_ff <= steps_in;
      rsp_ff   <= rsp_in;
   end

   // Miss counter memory: one read and one write port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= miss_mem[rd_addr];
      end
      if (wr_en) begin
         miss_mem[wr_addr] <= wr_data;
      end
   end

endmodule
`default_nettype wire
